// ===== src/dbst_pkg.sv =====
// ----------------------------------------------------------------------------
// dbst_pkg
// shared types and constants for the descending binary search table
// ----------------------------------------------------------------------------
package dbst_pkg;

  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_WIDTH   = 32;

  localparam logic FUNC_WRITE  = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_START,
    ST_PROBE,
    ST_FINISH
  } dbst_state_t;

  // controller to datapath
  typedef struct packed {
    logic take_item;   // input word accepted this cycle
    logic issue_read;  // launch a table read at the next midpoint
    logic probe;       // table read data is valid, apply the probe outcome
    logic finish;      // capture the search outcome into the pending result
    logic push_out;    // move the pending result into the output register
  } dbst_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_search;   // input word is a search
    logic range_open;  // bounds after this cycle still enclose an entry
    logic hit;         // probed entry equals the key
    logic out_free;    // output register can take a word this cycle
  } dbst_status_t;

endpackage

// ===== src/descending_binary_search_table_core.sv =====
// ----------------------------------------------------------------------------
// descending_binary_search_table_core
// key table sorted largest first, with write and binary search operations
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake          payload
//  in       sink       in_valid/in_stall  func, slot, key
//  out      source     out_valid/out_stall found, match_index
//  cfg      sink       cfg_valid/cfg_ready cfg_data (entry_count)
//
//  a write word gives no result
//  a search makes p probes, p up to log2 of depth, plus one
//  one probe per cycle, set by the table ram's registered read port
//  reset clears control and the entry count; table contents stay undefined
//  in_stall is high while a search is in flight; the result waits in the
//  output register while out_stall is high, and a further search finish waits
//
module descending_binary_search_table_core #(
  parameter int TABLE_DEPTH = dbst_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = dbst_pkg::DEF_KEY_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  // configuration write
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] cfg_data,
  // input words
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             func,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   slot,
  input  logic [KEY_WIDTH-1:0]             key,
  // result words
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             found,
  output logic [$clog2(TABLE_DEPTH)-1:0]   match_index
);

  import dbst_pkg::*;

  dbst_cmd_t    cmd;
  dbst_status_t st;

  // count register is always writable; the user must send writes only while idle, the block does not enforce it
  assign cfg_ready = 1'b1;

  // sequencer: idle, start, one state per probe loop, result hand-off
  dbst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  // table ram, bounds, midpoint and compare, output register
  dbst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (cfg_data),
    .func        (func),
    .slot        (slot),
    .key         (key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .match_index (match_index),
    .cmd         (cmd),
    .st          (st)
  );

endmodule

// ===== src/dbst_ram.sv =====
// ----------------------------------------------------------------------------
// dbst_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module dbst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/dbst_ctrl.sv =====
// ----------------------------------------------------------------------------
// dbst_ctrl
// search sequencer: accepts words, steps the probes, hands off the result
// ----------------------------------------------------------------------------
module dbst_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dbst_pkg::dbst_status_t st,
  output dbst_pkg::dbst_cmd_t    cmd
);

  import dbst_pkg::*;

  dbst_state_t state;
  dbst_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          if (st.is_search) begin
            state_next = ST_START;
          end
        end
      end
      ST_START: begin
        if (st.range_open) begin
          cmd.issue_read = 1'b1;
          state_next     = ST_PROBE;
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_PROBE: begin
        cmd.probe = 1'b1;
        priority if (st.hit) begin
          cmd.finish = 1'b1;
          state_next = ST_FINISH;
        end else if (st.range_open) begin
          cmd.issue_read = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (st.out_free) begin
          cmd.push_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_search_starts: assert property (@(posedge clk) disable iff (rst)
    (cmd.take_item && st.is_search) |=> (state == ST_START))
    else $error("accepted search did not start the probe sequence");

  a_read_or_finish: assert property (@(posedge clk) disable iff (rst)
    !(cmd.issue_read && cmd.finish))
    else $error("read issued on the cycle the search finished");

  a_probe_follows_read: assert property (@(posedge clk) disable iff (rst)
    cmd.issue_read |=> cmd.probe)
    else $error("read data not consumed in the cycle after the read");
`endif

endmodule

// ===== src/dbst_dp.sv =====
// ----------------------------------------------------------------------------
// dbst_dp
// search datapath: key table, bounds, midpoint, compare and result registers
// ----------------------------------------------------------------------------
module dbst_dp #(
  parameter int TABLE_DEPTH = dbst_pkg::DEF_TABLE_DEPTH,
  parameter int KEY_WIDTH   = dbst_pkg::DEF_KEY_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [$clog2(TABLE_DEPTH+1)-1:0] cfg_data,
  input  logic                             func,
  input  logic [$clog2(TABLE_DEPTH)-1:0]   slot,
  input  logic [KEY_WIDTH-1:0]             key,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             found,
  output logic [$clog2(TABLE_DEPTH)-1:0]   match_index,
  input  dbst_pkg::dbst_cmd_t              cmd,
  output dbst_pkg::dbst_status_t           st
);

  import dbst_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  logic [CNT_W-1:0]     entry_count;
  logic [KEY_WIDTH-1:0] key_q;
  logic [CNT_W-1:0]     low;
  logic [CNT_W-1:0]     high;
  logic [IDX_W-1:0]     mid_q;
  logic                 pend_found;
  logic [IDX_W-1:0]     pend_index;

  logic [CNT_W-1:0]     sat_count;
  logic                 slot_ok;
  logic                 ram_we;
  logic [KEY_WIDTH-1:0] probe_key;
  logic                 hit;
  logic [CNT_W-1:0]     step_low;
  logic [CNT_W-1:0]     step_high;
  logic [CNT_W-1:0]     mid_full;
  logic [IDX_W-1:0]     mid_next;

  // count register, saturated at the table depth for searches
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_data;
    end
  end

  assign sat_count = (entry_count > CNT_W'(TABLE_DEPTH)) ? CNT_W'(TABLE_DEPTH) : entry_count;
  assign slot_ok   = CNT_W'(slot) < CNT_W'(TABLE_DEPTH);
  assign ram_we    = cmd.take_item && (func == FUNC_WRITE) && slot_ok;

  // probe outcome and next bounds
  assign hit = (probe_key == key_q);

  always_comb begin
    step_low  = low;
    step_high = high;
    if (cmd.probe) begin
      if (key_q < probe_key) begin
        step_low = CNT_W'(mid_q) + CNT_W'(1);
      end else begin
        step_high = CNT_W'(mid_q);
      end
    end
  end

  assign mid_full = step_low + ((step_high - step_low) >> 1);
  assign mid_next = mid_full[IDX_W-1:0];

  dbst_ram #(
    .WIDTH (KEY_WIDTH),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (slot),
    .wdata (key),
    .re    (cmd.issue_read),
    .raddr (mid_next),
    .rdata (probe_key)
  );

  always_ff @(posedge clk) begin
    if (cmd.take_item && (func == FUNC_SEARCH)) begin
      key_q <= key;
      low   <= '0;
      high  <= sat_count;
    end else if (cmd.issue_read) begin
      low   <= step_low;
      high  <= step_high;
      mid_q <= mid_next;
    end
    if (cmd.finish) begin
      pend_found <= cmd.probe && hit;
      pend_index <= (cmd.probe && hit) ? mid_q : '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push_out) begin
      found       <= pend_found;
      match_index <= pend_index;
    end
  end

  assign st.is_search  = (func == FUNC_SEARCH);
  assign st.range_open = step_low < step_high;
  assign st.hit        = hit;
  assign st.out_free   = !out_valid || !out_stall;

`ifndef NO_ASSERTIONS
  a_mid_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.issue_read |=> (CNT_W'(mid_q) < high) && (low <= CNT_W'(mid_q)))
    else $error("probe index outside the search bounds");

  a_mid_in_count: assert property (@(posedge clk) disable iff (rst)
    cmd.issue_read |=> (CNT_W'(mid_q) < sat_count))
    else $error("probe index beyond the entry count");

  a_miss_index_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_index == '0))
    else $error("miss reported with a non-zero index");
`endif

endmodule
